// ----- rtl/core/ihsrgb_pkg.sv -----
package ihsrgb_pkg;

    // Field widths of the pixel stream.
    localparam int INT_W = 16;
    localparam int HUE_W = 15;
    localparam int SAT_W = 16;
    localparam int OUT_W = 18;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    // Rotation datapath. Angles are held in degrees times 2^22.
    localparam int XY_W      = 32;
    localparam int Z_W       = 32;
    localparam int QUAD_W    = 2;
    localparam int REST_W    = 13;
    localparam int GUARD     = 12;
    localparam int ANGLE_SH  = 16;
    localparam int TABLE_LEN = 24;

    localparam int ANGLE_STAGES_DEF = 16;

    localparam logic [HUE_W-1:0] HUE_TURN    = 15'd23040;
    localparam logic [HUE_W-1:0] HUE_QUARTER = 15'd5760;
    localparam logic [HUE_W-1:0] HUE_HALF    = 15'd11520;
    localparam logic [HUE_W-1:0] HUE_3QUART  = 15'd17280;

    localparam logic [QUAD_W-1:0] QUAD_0 = 2'd0;
    localparam logic [QUAD_W-1:0] QUAD_1 = 2'd1;
    localparam logic [QUAD_W-1:0] QUAD_2 = 2'd2;
    localparam logic [QUAD_W-1:0] QUAD_3 = 2'd3;

    // CORDIC gain and matrix coefficients, all Q30.
    localparam int GAIN_W  = 30;
    localparam int COEF_W  = 31;
    localparam logic [GAIN_W-1:0]        GAIN_Q30       = 30'd652032875;
    localparam logic signed [COEF_W-1:0] THIRD_Q30      = 31'sd357913941;
    localparam logic signed [COEF_W-1:0] RSQRT3_Q30     = 31'sd619925131;
    localparam logic signed [COEF_W-1:0] TWO_THIRDS_Q30 = 31'sd715827883;

    localparam int PROD_W   = XY_W + COEF_W;
    localparam int ACC_W    = 64;
    localparam int ACC_SH   = GUARD + 30;

    localparam logic signed [ACC_W-1:0] OUT_MAX = 64'sd131071;
    localparam logic signed [ACC_W-1:0] OUT_MIN = -64'sd131072;

    // Payload carried through the rotation stages.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [INT_W-1:0]       ival;
        logic [QUAD_W-1:0]      quad;
    } rot_t;

    // atan(2^-k) in degrees times 2^22, rounded to nearest.
    function automatic logic signed [Z_W-1:0] arc_entry(input int k);
        logic signed [Z_W-1:0] a;
        case (k)
            0:       a = 32'sd188743680;
            1:       a = 32'sd111421900;
            2:       a = 32'sd58872272;
            3:       a = 32'sd29884485;
            4:       a = 32'sd15000234;
            5:       a = 32'sd7507429;
            6:       a = 32'sd3754631;
            7:       a = 32'sd1877430;
            8:       a = 32'sd938729;
            9:       a = 32'sd469366;
            10:      a = 32'sd234683;
            11:      a = 32'sd117342;
            12:      a = 32'sd58671;
            13:      a = 32'sd29335;
            14:      a = 32'sd14668;
            15:      a = 32'sd7334;
            16:      a = 32'sd3667;
            17:      a = 32'sd1833;
            18:      a = 32'sd917;
            19:      a = 32'sd458;
            20:      a = 32'sd229;
            21:      a = 32'sd115;
            22:      a = 32'sd57;
            23:      a = 32'sd29;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/core/ihsrgb_cordic_stage.sv -----
module ihsrgb_cordic_stage #(
    parameter int K = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  ihsrgb_pkg::rot_t   in_data,
    output logic               up_ready,
    output logic               out_valid,
    output ihsrgb_pkg::rot_t   out_data,
    input  logic               dn_ready
);

    localparam logic signed [ihsrgb_pkg::Z_W-1:0] ARC = ihsrgb_pkg::arc_entry(K);

    logic                              valid_reg;
    ihsrgb_pkg::rot_t                  data_reg;
    ihsrgb_pkg::rot_t                  data_next;
    logic signed [ihsrgb_pkg::XY_W-1:0] dx;
    logic signed [ihsrgb_pkg::XY_W-1:0] dy;

    assign up_ready = !valid_reg || dn_ready;

    always_comb begin
        dx = in_data.y >>> K;
        dy = in_data.x >>> K;
        data_next = in_data;
        if (!in_data.z[ihsrgb_pkg::Z_W-1]) begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ARC;
        end else begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ARC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/core/ihs_to_rgb_convert_core.sv -----
// Channel | Ports                    | Contents
// --------+--------------------------+----------------------------------------------
// input   | s_tvalid s_tready s_tdata| intensity, hue_deg, saturation
// output  | m_tvalid m_tready m_tdata| red_out, green_out, blue_out (signed, saturated)
//
// One pixel is taken per cycle unless the output stalls; it passes the prep register, the
// chain of registered CORDIC rotation stages, and the product, sum and output registers.
// Reset clears only the valid bits of the stages.
// Each stage holds when it is full and its successor cannot take its transfer, so
// empty stages keep filling during an output stall and nothing is dropped or repeated.
module ihs_to_rgb_convert_core #(
    parameter int ANGLE_STAGES = ihsrgb_pkg::ANGLE_STAGES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] intensity, [30:16] hue_deg, [46:31] saturation, [47] zero
    input  logic [ihsrgb_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [17:0] red_out, [35:18] green_out, [53:36] blue_out, [55:54] zero
    output logic [ihsrgb_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int STAGE_COUNT = (ANGLE_STAGES > ihsrgb_pkg::TABLE_LEN) ?
                                 ihsrgb_pkg::TABLE_LEN : ANGLE_STAGES;
    localparam int XY_W   = ihsrgb_pkg::XY_W;
    localparam int PROD_W = ihsrgb_pkg::PROD_W;
    localparam int ACC_W  = ihsrgb_pkg::ACC_W;
    localparam int OUT_W  = ihsrgb_pkg::OUT_W;
    localparam int HUE_W  = ihsrgb_pkg::HUE_W;
    localparam int INT_W  = ihsrgb_pkg::INT_W;
    localparam int SAT_W  = ihsrgb_pkg::SAT_W;
    localparam int MUL_W  = SAT_W + ihsrgb_pkg::GAIN_W;
    localparam int X0_W   = MUL_W - (30 - ihsrgb_pkg::GUARD);

    function automatic logic [OUT_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] s;
        logic [OUT_W-1:0]        r;
        s = acc >>> ihsrgb_pkg::ACC_SH;
        if (s > ihsrgb_pkg::OUT_MAX) begin
            r = ihsrgb_pkg::OUT_MAX[OUT_W-1:0];
        end else if (s < ihsrgb_pkg::OUT_MIN) begin
            r = ihsrgb_pkg::OUT_MIN[OUT_W-1:0];
        end else begin
            r = s[OUT_W-1:0];
        end
        return r;
    endfunction

    // ---------------- prep stage: hue wrap, quadrant split, gain multiply
    logic [INT_W-1:0]          s_ival;
    logic [HUE_W-1:0]          s_hue;
    logic [SAT_W-1:0]          s_sat;
    logic [HUE_W-1:0]          hue_w;
    logic [HUE_W-1:0]          rest;
    logic [ihsrgb_pkg::QUAD_W-1:0] quad;
    logic [MUL_W-1:0]          gain_prod;
    ihsrgb_pkg::rot_t          prep_next;
    ihsrgb_pkg::rot_t          prep_reg;
    logic                      prep_valid_reg;

    assign s_ival = s_tdata[INT_W-1:0];
    assign s_hue  = s_tdata[INT_W+HUE_W-1:INT_W];
    assign s_sat  = s_tdata[INT_W+HUE_W+SAT_W-1:INT_W+HUE_W];

    always_comb begin
        hue_w = (s_hue >= ihsrgb_pkg::HUE_TURN) ? (s_hue - ihsrgb_pkg::HUE_TURN) : s_hue;
        if (hue_w >= ihsrgb_pkg::HUE_3QUART) begin
            quad = ihsrgb_pkg::QUAD_3;
            rest = hue_w - ihsrgb_pkg::HUE_3QUART;
        end else if (hue_w >= ihsrgb_pkg::HUE_HALF) begin
            quad = ihsrgb_pkg::QUAD_2;
            rest = hue_w - ihsrgb_pkg::HUE_HALF;
        end else if (hue_w >= ihsrgb_pkg::HUE_QUARTER) begin
            quad = ihsrgb_pkg::QUAD_1;
            rest = hue_w - ihsrgb_pkg::HUE_QUARTER;
        end else begin
            quad = ihsrgb_pkg::QUAD_0;
            rest = hue_w;
        end
        gain_prod = MUL_W'(s_sat) * MUL_W'(ihsrgb_pkg::GAIN_Q30);
        prep_next.x = $signed(XY_W'(gain_prod[MUL_W-1:MUL_W-X0_W]));
        prep_next.y = '0;
        prep_next.z = $signed(ihsrgb_pkg::Z_W'({rest[ihsrgb_pkg::REST_W-1:0],
                                                {ihsrgb_pkg::ANGLE_SH{1'b0}}}));
        prep_next.ival = s_ival;
        prep_next.quad = quad;
    end

    // ---------------- rotation chain
    logic                  cv   [STAGE_COUNT+1];
    logic                  crdy [STAGE_COUNT+1];
    ihsrgb_pkg::rot_t      cd   [STAGE_COUNT+1];

    assign s_tready = !prep_valid_reg || crdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (s_tready) begin
            prep_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            prep_reg <= prep_next;
        end
    end

    assign cv[0] = prep_valid_reg;
    assign cd[0] = prep_reg;

    for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_rot
        ihsrgb_cordic_stage #(
            .K(k)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cv[k]),
            .in_data   (cd[k]),
            .up_ready  (crdy[k]),
            .out_valid (cv[k+1]),
            .out_data  (cd[k+1]),
            .dn_ready  (crdy[k+1])
        );
    end

    // ---------------- product stage: quadrant swap and matrix products
    ihsrgb_pkg::rot_t          rot;
    logic signed [XY_W-1:0]    v1;
    logic signed [XY_W-1:0]    v2;
    logic signed [PROD_W-1:0]  p1_reg;
    logic signed [PROD_W-1:0]  p2_reg;
    logic signed [PROD_W-1:0]  p3_reg;
    logic signed [PROD_W-1:0]  p1_next;
    logic signed [PROD_W-1:0]  p2_next;
    logic signed [PROD_W-1:0]  p3_next;
    logic [INT_W-1:0]          prod_ival_reg;
    logic                      prod_valid_reg;
    logic                      prod_rdy;

    assign rot = cd[STAGE_COUNT];
    assign crdy[STAGE_COUNT] = prod_rdy;

    always_comb begin
        case (rot.quad)
            ihsrgb_pkg::QUAD_0: begin
                v1 = rot.x;
                v2 = rot.y;
            end
            ihsrgb_pkg::QUAD_1: begin
                v1 = -rot.y;
                v2 = rot.x;
            end
            ihsrgb_pkg::QUAD_2: begin
                v1 = -rot.x;
                v2 = -rot.y;
            end
            default: begin
                v1 = rot.y;
                v2 = -rot.x;
            end
        endcase
        p1_next = v1 * ihsrgb_pkg::THIRD_Q30;
        p2_next = v2 * ihsrgb_pkg::RSQRT3_Q30;
        p3_next = v1 * ihsrgb_pkg::TWO_THIRDS_Q30;
    end

    // ---------------- sum stage and output stage
    logic signed [ACC_W-1:0]   base_h;
    logic signed [ACC_W-1:0]   t_reg;
    logic signed [ACC_W-1:0]   b_reg;
    logic signed [PROD_W-1:0]  q_reg;
    logic                      sum_valid_reg;
    logic                      sum_rdy;
    logic                      out_valid_reg;
    logic                      out_rdy;
    logic [OUT_W-1:0]          red_reg;
    logic [OUT_W-1:0]          green_reg;
    logic [OUT_W-1:0]          blue_reg;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   g_acc;

    assign out_rdy  = !out_valid_reg || m_tready;
    assign sum_rdy  = !sum_valid_reg || out_rdy;
    assign prod_rdy = !prod_valid_reg || sum_rdy;

    // The intensity sits at GUARD + 30 fraction bits, so its low bits are zero and the
    // rounding half can be placed there directly.
    assign base_h = $signed({{(ACC_W - INT_W - ihsrgb_pkg::ACC_SH){1'b0}}, prod_ival_reg,
                             1'b1, {(ihsrgb_pkg::ACC_SH - 1){1'b0}}});

    assign r_acc = t_reg + ACC_W'(q_reg);
    assign g_acc = t_reg - ACC_W'(q_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (prod_rdy) begin
                prod_valid_reg <= cv[STAGE_COUNT];
            end
            if (sum_rdy) begin
                sum_valid_reg <= prod_valid_reg;
            end
            if (out_rdy) begin
                out_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_rdy && cv[STAGE_COUNT]) begin
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            p3_reg        <= p3_next;
            prod_ival_reg <= rot.ival;
        end
        if (sum_rdy && prod_valid_reg) begin
            t_reg <= base_h - ACC_W'(p1_reg);
            b_reg <= base_h + ACC_W'(p3_reg);
            q_reg <= p2_reg;
        end
        if (out_rdy && sum_valid_reg) begin
            red_reg   <= finish(r_acc);
            green_reg <= finish(g_acc);
            blue_reg  <= finish(b_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ihsrgb_pkg::M_TDATA_W - 3 * OUT_W){1'b0}},
                       blue_reg, green_reg, red_reg};

endmodule
